/* hw/rtl/dsf_pkg.sv */
// Shared types, constants and tables for the decimal string to fixed-point block.
// Used by the front classifier, the token queue, the back parser, the top level and the checker.
package dsf_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int MAG_BITS      = VALUE_BITS - 1;
  localparam int CHAR_BITS     = 8;
  localparam int DP_BITS       = 4;
  localparam int DIGIT_BITS    = 4;
  localparam int STATUS_BITS   = 2;
  localparam int USER_BITS     = STATUS_BITS + 1;
  localparam int POW_BITS      = 30;
  localparam int MAX_SCALE     = 9;
  localparam int PROD_BITS     = MAG_BITS + POW_BITS;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = QPTR_BITS + 1;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_DECIMAL_PLACES = 1'b0;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

  typedef logic [MAG_BITS-1:0] mag_t;
  localparam mag_t MAX_MAG = '1;

  typedef enum logic [2:0] {
    KIND_DIGIT = 3'd0,
    KIND_POINT = 3'd1,
    KIND_MINUS = 3'd2,
    KIND_OTHER = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DIGIT_BITS-1:0] digit;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } push_t;

  // Ten to the k for the final scaling, k up to MAX_SCALE
  function automatic logic [POW_BITS-1:0] pow10(input logic [DP_BITS-1:0] k);
    logic [POW_BITS-1:0] p;
    case (k)
      4'd0:    p = POW_BITS'(1);
      4'd1:    p = POW_BITS'(10);
      4'd2:    p = POW_BITS'(100);
      4'd3:    p = POW_BITS'(1000);
      4'd4:    p = POW_BITS'(10000);
      4'd5:    p = POW_BITS'(100000);
      4'd6:    p = POW_BITS'(1000000);
      4'd7:    p = POW_BITS'(10000000);
      4'd8:    p = POW_BITS'(100000000);
      4'd9:    p = POW_BITS'(1000000000);
      default: p = POW_BITS'(1);
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/dsf_front.sv */
// Front classifier: takes characters from the input stream and turns them into tokens.
// Depends on dsf_pkg; feeds dsf_queue.
module dsf_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dsf_pkg::CHAR_BITS-1:0]  s_tdata,
  input  logic                           q_full,
  output dsf_pkg::push_t                 push
);

  logic is_digit;

  assign is_digit = (s_tdata >= dsf_pkg::CHAR_ZERO) && (s_tdata <= dsf_pkg::CHAR_NINE);
  assign s_tready = !q_full;

  always_comb begin
    push.valid     = s_tvalid && !q_full;
    // ASCII digits carry their value in the low nibble
    push.tok.digit = s_tdata[dsf_pkg::DIGIT_BITS-1:0];
    if (s_tdata == dsf_pkg::CHAR_NUL) begin
      push.tok.kind = dsf_pkg::KIND_END;
    end else if (is_digit) begin
      push.tok.kind = dsf_pkg::KIND_DIGIT;
    end else if (s_tdata == dsf_pkg::CHAR_DOT || s_tdata == dsf_pkg::CHAR_COMMA) begin
      push.tok.kind = dsf_pkg::KIND_POINT;
    end else if (s_tdata == dsf_pkg::CHAR_MINUS) begin
      push.tok.kind = dsf_pkg::KIND_MINUS;
    end else begin
      push.tok.kind = dsf_pkg::KIND_OTHER;
    end
  end

endmodule

/* hw/rtl/dsf_queue.sv */
// Short token queue between the front classifier and the back parser.
// Depends on dsf_pkg.
module dsf_queue (
  input  logic             clk,
  input  logic             rst,
  input  dsf_pkg::push_t   push,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output dsf_pkg::token_t  head
);

  dsf_pkg::token_t               mem [dsf_pkg::QUEUE_DEPTH];
  logic [dsf_pkg::QPTR_BITS-1:0] wptr;
  logic [dsf_pkg::QPTR_BITS-1:0] rptr;
  logic [dsf_pkg::QCNT_BITS-1:0] count;
  logic                          do_pop;

  assign full       = (count == dsf_pkg::QCNT_BITS'(dsf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wptr] <= push.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/dsf_back.sv */
// Back parser: consumes tokens, accumulates the magnitude, and on a terminator
// scales, signs and registers the result. Depends on dsf_pkg.
module dsf_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dsf_pkg::DP_BITS-1:0]        decimal_places,
  input  logic                               head_valid,
  input  dsf_pkg::token_t                    head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dsf_pkg::VALUE_BITS-1:0]     m_tdata,
  output logic [dsf_pkg::USER_BITS-1:0]      m_tuser
);

  dsf_pkg::mag_t                 magnitude;
  logic                          overflowed;
  logic                          at_string_start;
  logic                          at_first_body_char;
  logic                          is_negative;
  logic                          seen_point;
  logic [dsf_pkg::DP_BITS-1:0]   fraction_digits_kept;
  logic                          stopped;
  dsf_pkg::status_t              error_code;

  logic [dsf_pkg::MAG_BITS+3:0]  acc;
  logic                          step_sat;
  dsf_pkg::mag_t                 mag_step;

  logic [dsf_pkg::DP_BITS-1:0]   scale_k;
  logic [dsf_pkg::DP_BITS-1:0]   scale_kc;
  logic                          scale_big;
  logic [dsf_pkg::PROD_BITS-1:0] prod;
  logic                          fin_sat;
  dsf_pkg::mag_t                 fin_mag;
  logic [dsf_pkg::VALUE_BITS-1:0] fin_abs;
  logic [dsf_pkg::VALUE_BITS-1:0] fin_value;
  dsf_pkg::status_t              fin_status;
  logic                          is_end;

  // Accumulate one digit: m * 10 + d, clamped
  always_comb begin
    acc = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1)
        + {{dsf_pkg::MAG_BITS{1'b0}}, head.digit};
    step_sat = acc > {4'b0, dsf_pkg::MAX_MAG};
    mag_step = step_sat ? dsf_pkg::MAX_MAG : acc[dsf_pkg::MAG_BITS-1:0];
  end

  // Final scaling by ten to the missing fraction digits
  always_comb begin
    scale_k   = (decimal_places > fraction_digits_kept) ?
                (decimal_places - fraction_digits_kept) : '0;
    scale_big = scale_k > dsf_pkg::DP_BITS'(dsf_pkg::MAX_SCALE);
    scale_kc  = scale_big ? dsf_pkg::DP_BITS'(dsf_pkg::MAX_SCALE) : scale_k;
    prod      = dsf_pkg::PROD_BITS'(magnitude) *
                dsf_pkg::PROD_BITS'(dsf_pkg::pow10(scale_kc));
    fin_sat   = overflowed || (scale_big && magnitude != '0) ||
                (prod > dsf_pkg::PROD_BITS'(dsf_pkg::MAX_MAG));
    fin_mag   = fin_sat ? dsf_pkg::MAX_MAG : prod[dsf_pkg::MAG_BITS-1:0];
    fin_abs   = {1'b0, fin_mag};
    fin_value = is_negative ? (~fin_abs + 1'b1) : fin_abs;
    if (at_first_body_char) begin
      fin_status = dsf_pkg::STATUS_EMPTY;
    end else begin
      fin_status = error_code;
    end
  end

  assign is_end = (head.kind == dsf_pkg::KIND_END);
  // Characters that give no result keep flowing while a result waits
  assign pop    = head_valid && (!is_end || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      if (fin_status == dsf_pkg::STATUS_OK) begin
        m_tdata <= fin_value;
        m_tuser <= {fin_sat, fin_status};
      end else begin
        m_tdata <= '0;
        m_tuser <= {1'b0, fin_status};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && is_end)) begin
      magnitude            <= '0;
      overflowed           <= 1'b0;
      at_string_start      <= 1'b1;
      at_first_body_char   <= 1'b1;
      is_negative          <= 1'b0;
      seen_point           <= 1'b0;
      fraction_digits_kept <= '0;
      stopped              <= 1'b0;
      error_code           <= dsf_pkg::STATUS_OK;
    end else if (pop) begin
      at_string_start <= 1'b0;
      if (at_string_start && head.kind == dsf_pkg::KIND_MINUS) begin
        is_negative <= 1'b1;
      end else if (!stopped) begin
        case (head.kind)
          dsf_pkg::KIND_DIGIT: begin
            at_first_body_char <= 1'b0;
            if (!seen_point) begin
              magnitude  <= mag_step;
              overflowed <= overflowed | step_sat;
            end else if (fraction_digits_kept < decimal_places) begin
              magnitude            <= mag_step;
              overflowed           <= overflowed | step_sat;
              fraction_digits_kept <= fraction_digits_kept + 1'b1;
            end
          end
          dsf_pkg::KIND_POINT: begin
            at_first_body_char <= 1'b0;
            seen_point         <= 1'b1;
          end
          default: begin
            // Invalid character: stop, and flag it if nothing came before
            if (at_first_body_char) begin
              error_code <= dsf_pkg::STATUS_INVALID;
            end
            at_first_body_char <= 1'b0;
            stopped            <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/decimal_string_to_fixed_top.sv */
// Top level of the decimal string to fixed-point converter: APB register, front, queue, back.
// Depends on dsf_pkg, dsf_front, dsf_queue and dsf_back.
//
// Usage:
//   Input stream s_*: one ASCII character per item in s_tdata[7:0]. A zero byte ends the
//   string and produces exactly one result; all other characters produce none.
//   Output stream m_*: m_tdata is the signed fixed-point value, m_tuser holds the status
//   (ok, empty, invalid first character) and the saturation flag.
//   APB register decimal_places at byte address 0 sets the implied decimal digits;
//   write it only while no string is in flight.
// Timing:
//   One character per cycle sustained while the token queue is not full. A terminator accepted
//   on the input is written into the four-entry token queue, then taken by the parser, which
//   registers its result onto m_*; the final scaling is a single multiply by a power of ten.
//   While a result waits on m_tready, the parser keeps consuming characters that give no
//   result; only the next terminator waits, and s_tready drops once the queue is full.
// Reset:
//   rst clears the queue, the parse state and decimal_places, and drops m_tvalid.
module decimal_string_to_fixed_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsf_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [dsf_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [dsf_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dsf_pkg::CHAR_BITS-1:0]        s_tdata,   // [7:0] character
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dsf_pkg::VALUE_BITS-1:0]       m_tdata,   // [31:0] value
  output logic [dsf_pkg::USER_BITS-1:0]        m_tuser    // [1:0] status, [2] saturated
);

  logic [dsf_pkg::DP_BITS-1:0] decimal_places;
  dsf_pkg::push_t              push;
  logic                        q_full;
  logic                        head_valid;
  dsf_pkg::token_t             head;
  logic                        pop;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == dsf_pkg::REG_DECIMAL_PLACES);
  assign prdata  = reg_sel ? dsf_pkg::APB_DATA_BITS'(decimal_places) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_places <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      decimal_places <= pwdata[dsf_pkg::DP_BITS-1:0];
    end
  end

  dsf_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push)
  );

  dsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .decimal_places (decimal_places),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser)
  );

endmodule

/* hw/rtl/dsf_checker.sv */
// Port-level checker for decimal_string_to_fixed_top, attached with a bind.
// Depends on dsf_pkg.
module dsf_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [dsf_pkg::VALUE_BITS-1:0]       m_tdata,
  input logic [dsf_pkg::USER_BITS-1:0]        m_tuser
);

  localparam logic [dsf_pkg::VALUE_BITS-1:0] SAT_POS = {1'b0, dsf_pkg::MAX_MAG};
  localparam logic [dsf_pkg::VALUE_BITS-1:0] SAT_NEG = ~SAT_POS + 1'b1;

  // Held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[dsf_pkg::STATUS_BITS-1:0] != dsf_pkg::STATUS_OK
      |-> m_tdata == '0 && !m_tuser[dsf_pkg::STATUS_BITS])
    else $error("error result carries a value or saturation flag");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[dsf_pkg::STATUS_BITS] |-> m_tdata == SAT_POS || m_tdata == SAT_NEG)
    else $error("saturated result is not the clamp value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[dsf_pkg::STATUS_BITS-1:0] == dsf_pkg::STATUS_OK ||
                 m_tuser[dsf_pkg::STATUS_BITS-1:0] == dsf_pkg::STATUS_EMPTY ||
                 m_tuser[dsf_pkg::STATUS_BITS-1:0] == dsf_pkg::STATUS_INVALID)
    else $error("undefined status code");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind decimal_string_to_fixed_top dsf_checker u_dsf_checker (.*);
